// ----- hdl/sfr_pkg.sv -----
package sfr_pkg;

   // Frame header bytes.
   localparam logic [7:0] HEADER_FIRST  = 8'h55;
   localparam logic [7:0] HEADER_SECOND = 8'hAA;

   // End-of-frame status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_CSUM_ERR  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

   // Parser phases, one-hot.
   typedef enum logic [7:0] {
      PH_HUNT  = 8'b0000_0001,
      PH_HDR2  = 8'b0000_0010,
      PH_VER   = 8'b0000_0100,
      PH_CMD   = 8'b0000_1000,
      PH_LENHI = 8'b0001_0000,
      PH_LENLO = 8'b0010_0000,
      PH_DATA  = 8'b0100_0000,
      PH_CSUM  = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_word_type;

   typedef struct packed {
      logic        frame_end;
      logic [7:0]  payload_byte;
      logic [7:0]  payload_index;
      logic [7:0]  frame_version;
      logic [7:0]  frame_command;
      logic [15:0] frame_length;
      logic [1:0]  status;
   } rsp_word_type;

endpackage

// ----- hdl/sfr_stream_if.sv -----
interface sfr_stream_if #(
   parameter type payload_type = logic [7:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/sfr_parser.sv -----
module sfr_parser
   import sfr_pkg::*;
#(
   parameter int MAX_PAYLOAD = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic [7:0]   rx_byte,
   output logic         result_valid,
   output rsp_word_type result
);

   localparam int CountWidth = $clog2(MAX_PAYLOAD + 1);

   phase_type             phase_ff,   phase_in;
   logic [7:0]            version_ff, version_in;
   logic [7:0]            command_ff, command_in;
   logic [15:0]           length_ff,  length_in;
   logic [CountWidth-1:0] count_ff,   count_in;
   logic [7:0]            sum_ff,     sum_in;

   logic [7:0]            sum_add;
   logic [CountWidth-1:0] count_next;
   logic [CountWidth+7:0] count_ext;
   logic                  too_long;

   assign sum_add    = sum_ff + rx_byte;
   assign count_next = count_ff + 1'b1;
   assign count_ext  = {8'b0, count_ff};
   // Length as it stands once the low byte arrives.
   assign too_long   = {1'b0, length_ff[15:8], rx_byte} > 17'(MAX_PAYLOAD);

   always_comb begin
      phase_in     = phase_ff;
      version_in   = version_ff;
      command_in   = command_ff;
      length_in    = length_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      result_valid = 1'b0;
      result.frame_end     = 1'b0;
      result.payload_byte  = 8'h00;
      result.payload_index = 8'h00;
      result.status        = STATUS_OK;

      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == HEADER_FIRST) begin
               sum_in   = HEADER_FIRST;
               phase_in = PH_HDR2;
            end
         end
         PH_HDR2: begin
            // Anything but the second header byte drops back to hunting.
            if (rx_byte == HEADER_SECOND) begin
               sum_in   = sum_add;
               phase_in = PH_VER;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_VER: begin
            version_in = rx_byte;
            sum_in     = sum_add;
            phase_in   = PH_CMD;
         end
         PH_CMD: begin
            command_in = rx_byte;
            sum_in     = sum_add;
            phase_in   = PH_LENHI;
         end
         PH_LENHI: begin
            length_in = {rx_byte, 8'h00};
            sum_in    = sum_add;
            phase_in  = PH_LENLO;
         end
         PH_LENLO: begin
            length_in = {length_ff[15:8], rx_byte};
            sum_in    = sum_add;
            count_in  = '0;
            if (too_long) begin
               phase_in         = PH_HUNT;
               result_valid     = 1'b1;
               result.frame_end = 1'b1;
               result.status    = STATUS_OVERFLOW;
            end else if (length_in == 16'h0000) begin
               phase_in = PH_CSUM;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            result_valid         = 1'b1;
            result.payload_byte  = rx_byte;
            result.payload_index = count_ext[7:0];
            sum_in               = sum_add;
            count_in             = count_next;
            if (17'(count_next) >= {1'b0, length_ff}) begin
               phase_in = PH_CSUM;
            end
         end
         PH_CSUM: begin
            phase_in         = PH_HUNT;
            result_valid     = 1'b1;
            result.frame_end = 1'b1;
            result.status    = (rx_byte == sum_ff) ? STATUS_OK : STATUS_CSUM_ERR;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase

      result.frame_version = version_ff;
      result.frame_command = command_ff;
      result.frame_length  = length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         version_ff <= '0;
         command_ff <= '0;
         length_ff  <= '0;
         count_ff   <= '0;
         sum_ff     <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         version_ff <= version_in;
         command_ff <= command_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
         sum_ff     <= sum_in;
      end
   end

endmodule

// ----- hdl/serial_frame_receiver.sv -----
// Serial frame receiver.
// The req_stream channel carries one received serial byte per word. The block
// hunts for the header 0x55 0xAA, captures version, command and the
// big-endian length, and emits one rsp_stream word per payload byte, then an
// end-of-frame word whose status is ok or checksum mismatch. A length above
// MAX_PAYLOAD ends the frame at once with an overflow status. Header, version,
// command and length bytes produce no word, save the overflow end-of-frame word.
// Data path: a byte accepted from req_stream lands in the input register; the
// parser handles it from there and its result word is registered in the
// result register, which drives rsp_stream.
// Throughput: one byte per cycle while rsp_stream takes its words; the parser
// state update is a single pass of short logic between the two registers.
// When the receiver holds off rsp_stream, the result register keeps its word;
// bytes that produce no word still pass, and a byte that does produce one
// waits in the input register, after which req_stream.ready drops.
// Reset (synchronous, active high) empties both registers and returns the
// parser to hunting for the first header byte with all captured fields zero.
module serial_frame_receiver
   import sfr_pkg::*;
#(
   parameter int MAX_PAYLOAD = 256
) (
   input  logic clock,
   input  logic reset,
   sfr_stream_if.sink   req_stream,
   sfr_stream_if.source rsp_stream
);

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff,  in_byte_in;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff,  out_word_in;

   logic         parse_valid;
   rsp_word_type parse_word;
   logic         out_space;
   logic         advance;
   logic         req_take;

   // The result register can take a word when empty or being drained.
   assign out_space = !out_valid_ff || rsp_stream.ready;
   // A buffered byte moves through the parser unless its word has nowhere to go.
   assign advance   = in_valid_ff && (!parse_valid || out_space);
   assign req_stream.ready = !in_valid_ff || advance;
   assign req_take  = req_stream.valid && req_stream.ready;

   sfr_parser #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .rx_byte     (in_byte_ff),
      .result_valid(parse_valid),
      .result      (parse_word)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_stream.payload.rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (advance && parse_valid) begin
         out_valid_in = 1'b1;
         out_word_in  = parse_word;
      end else if (rsp_stream.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_stream.valid   = out_valid_ff;
   assign rsp_stream.payload = out_word_ff;

endmodule
